FILE: sv/nmm_pkg.sv
// Package for the negacyclic monomial multiply-minus-one block.
// Holds field widths, the action codes and the pipeline tag type.
// No dependencies.
`default_nettype none

package nmm_pkg;

	// polynomial size, a power of two that fills the index field
	localparam int unsigned POLY_DEGREE = 1024;
	localparam int unsigned IDX_W       = 10;
	localparam int unsigned SHIFT_W     = IDX_W + 1;
	localparam int unsigned COEF_W      = 61;

	// modulus after reset
	localparam logic [COEF_W-1:0] MOD_RESET = COEF_W'(12289);

	// item action codes
	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_READ = 1'b1
	} action_t;

	// side information that travels with a read word
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] index;
		logic             negate;
		logic             force_zero;
	} tag_t;

endpackage

`default_nettype wire

FILE: sv/nmm_item_if.sv
// Input channel interface: valid/ready plus the item fields.
// Depends on nmm_pkg.
`default_nettype none

interface nmm_item_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [nmm_pkg::IDX_W-1:0]  index;
	logic [nmm_pkg::COEF_W-1:0] coefficient;
	logic [nmm_pkg::SHIFT_W-1:0] shift_amount;

	modport source (output valid, output action, output index, output coefficient,
		output shift_amount, input ready);
	modport sink (input valid, input action, input index, input coefficient,
		input shift_amount, output ready);
endinterface

`default_nettype wire

FILE: sv/nmm_result_if.sv
// Output channel interface: valid/ready plus the result fields.
// Depends on nmm_pkg.
`default_nettype none

interface nmm_result_if;
	logic                       valid;
	logic                       ready;
	logic [nmm_pkg::IDX_W-1:0]  result_index;
	logic [nmm_pkg::COEF_W-1:0] result_value;

	modport source (output valid, output result_index, output result_value, input ready);
	modport sink (input valid, input result_index, input result_value, output ready);
endinterface

`default_nettype wire

FILE: sv/nmm_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module nmm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

FILE: sv/nmm_reduce.sv
// Pipelined restoring reduction of two words modulo q, one quotient bit per stage.
// Depends on nmm_pkg.
`default_nettype none

module nmm_reduce (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic [nmm_pkg::COEF_W-1:0] modulus,
	input  wire nmm_pkg::tag_t              tag_in,
	input  wire logic [nmm_pkg::COEF_W-1:0] rot_in,
	input  wire logic [nmm_pkg::COEF_W-1:0] cur_in,
	output nmm_pkg::tag_t                   tag_out,
	output logic      [nmm_pkg::COEF_W-1:0] rot_out,
	output logic      [nmm_pkg::COEF_W-1:0] cur_out
);

	localparam int unsigned W      = nmm_pkg::COEF_W;
	localparam int unsigned STAGES = nmm_pkg::COEF_W;

	// one restoring step: shift in a bit, subtract q if it fits
	function automatic logic [W-1:0] mod_step(
		input logic [W-1:0] rem,
		input logic         b,
		input logic [W-1:0] q
	);
		logic [W:0] trial;
		logic [W:0] diff;
		trial = {rem, b};
		diff  = trial - {1'b0, q};
		return diff[W] ? trial[W-1:0] : diff[W-1:0];
	endfunction

	// per-stage registers: partial remainders, dividends, tags
	logic [W-1:0]  rot_rem_s [STAGES];
	logic [W-1:0]  rot_x_s   [STAGES];
	logic [W-1:0]  cur_rem_s [STAGES];
	logic [W-1:0]  cur_x_s   [STAGES];
	nmm_pkg::tag_t tag_s     [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [W-1:0]  rot_rem_prev;
		logic [W-1:0]  rot_x_prev;
		logic [W-1:0]  cur_rem_prev;
		logic [W-1:0]  cur_x_prev;
		nmm_pkg::tag_t tag_prev;

		if (k == 0) begin : g_first
			assign rot_rem_prev = '0;
			assign rot_x_prev   = rot_in;
			assign cur_rem_prev = '0;
			assign cur_x_prev   = cur_in;
			assign tag_prev     = tag_in;
		end else begin : g_next
			assign rot_rem_prev = rot_rem_s[k-1];
			assign rot_x_prev   = rot_x_s[k-1];
			assign cur_rem_prev = cur_rem_s[k-1];
			assign cur_x_prev   = cur_x_s[k-1];
			assign tag_prev     = tag_s[k-1];
		end

		// tag of the stage, valid bit included
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (en) begin
				tag_s[k] <= tag_prev;
			end
		end

		// datapath of the stage, bit W-1-k of each dividend
		always_ff @(posedge clk) begin
			if (en) begin
				rot_x_s[k]   <= rot_x_prev;
				cur_x_s[k]   <= cur_x_prev;
				rot_rem_s[k] <= mod_step(rot_rem_prev, rot_x_prev[W-1-k], modulus);
				cur_rem_s[k] <= mod_step(cur_rem_prev, cur_x_prev[W-1-k], modulus);
			end
		end
	end

	assign tag_out = tag_s[STAGES-1];
	assign rot_out = rot_rem_s[STAGES-1];
	assign cur_out = cur_rem_s[STAGES-1];

endmodule

`default_nettype wire

FILE: sv/nmm_combine.sv
// Two-stage sign application and modular subtract of the reduced words.
// Depends on nmm_pkg.
`default_nettype none

module nmm_combine (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic [nmm_pkg::COEF_W-1:0] modulus,
	input  wire nmm_pkg::tag_t              tag_in,
	input  wire logic [nmm_pkg::COEF_W-1:0] rot_in,
	input  wire logic [nmm_pkg::COEF_W-1:0] cur_in,
	output nmm_pkg::tag_t                   tag_out,
	output logic      [nmm_pkg::COEF_W-1:0] value_out
);

	localparam int unsigned W = nmm_pkg::COEF_W;

	nmm_pkg::tag_t tag_s1;
	logic [W-1:0]  rot_s1;
	logic [W-1:0]  cur_s1;
	logic [W-1:0]  qmc_s1;
	nmm_pkg::tag_t tag_s2;
	logic [W-1:0]  value_s2;

	logic [W-1:0]  rot_signed;
	logic [W-1:0]  diff;
	logic [W-1:0]  wrap;

	// negation of zero stays zero
	assign rot_signed = (tag_in.negate && (rot_in != '0)) ? (modulus - rot_in) : rot_in;

	// both subtract candidates, pick by compare
	assign diff = rot_s1 - cur_s1;
	assign wrap = rot_s1 + qmc_s1;

	// tags, valid bits included
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1 <= rot_signed;
			cur_s1 <= cur_in;
			qmc_s1 <= modulus - cur_in;
			if (tag_s1.force_zero) begin
				value_s2 <= '0;
			end else if (rot_s1 >= cur_s1) begin
				value_s2 <= diff;
			end else begin
				value_s2 <= wrap;
			end
		end
	end

	assign tag_out   = tag_s2;
	assign value_out = value_s2;

endmodule

`default_nettype wire

FILE: sv/negacyclic_monomial_mul_minus_one.sv
// Top level of the negacyclic monomial multiply-minus-one block.
// Depends on nmm_pkg, nmm_item_if, nmm_result_if, nmm_ram, nmm_reduce, nmm_combine.
`default_nettype none

// The block stores one polynomial of 1024 coefficients and answers single
// coefficients of P(X)*(X^a - 1) mod (X^1024 + 1, q). A load word writes one
// coefficient and gives no result; a read word gives one result: the memory
// read (two ports, for the rotated and the direct coefficient) is registered
// at the edge that takes it, then come the bit-per-stage reduction modulo q,
// the sign and subtract stages and one output register. One word is taken
// every cycle; the whole pipeline holds while a result waits.
// Coefficients are stored unreduced. Reading a coefficient that was never
// loaded gives an undefined value. Change the modulus only while idle.
module negacyclic_monomial_mul_minus_one (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       modulus_we,
	input  wire logic [nmm_pkg::COEF_W-1:0] modulus_wdata,
	nmm_item_if.sink                        item,
	nmm_result_if.source                    result
);

	localparam int unsigned IDX_W = nmm_pkg::IDX_W;
	localparam int unsigned W     = nmm_pkg::COEF_W;
	localparam logic [IDX_W:0] DEGREE = (IDX_W+1)'(nmm_pkg::POLY_DEGREE);

	logic [W-1:0]     modulus_q;
	logic             adv;
	logic             accept;
	logic             load_we;
	logic             upper;
	logic [IDX_W-1:0] rot_amt;
	logic [IDX_W-1:0] src_idx;
	logic             idx_out_of_range;

	nmm_pkg::tag_t    tag_s1;
	logic [W-1:0]     rot_raw;
	logic [W-1:0]     cur_raw;
	nmm_pkg::tag_t    red_tag;
	logic [W-1:0]     red_rot;
	logic [W-1:0]     red_cur;
	nmm_pkg::tag_t    fin_tag;
	logic [W-1:0]     fin_value;

	logic             result_valid_q;
	logic [IDX_W-1:0] result_index_q;
	logic [W-1:0]     result_value_q;

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= nmm_pkg::MOD_RESET;
		end else if (modulus_we) begin
			modulus_q <= modulus_wdata;
		end
	end

	// pipeline moves whenever the output register can take a word
	assign adv         = !result_valid_q || result.ready;
	assign item.ready  = adv;
	assign accept      = item.valid && adv;

	// exponent split: top bit flips the sign, low bits rotate
	assign upper            = item.shift_amount[IDX_W];
	assign rot_amt          = item.shift_amount[IDX_W-1:0];
	assign src_idx          = item.index - rot_amt;
	assign idx_out_of_range = {1'b0, item.index} >= DEGREE;
	assign load_we          = accept && (item.action == nmm_pkg::ACT_LOAD) && !idx_out_of_range;

	nmm_ram #(
		.WIDTH (W),
		.DEPTH (nmm_pkg::POLY_DEGREE)
	) u_store (
		.clk     (clk),
		.we      (load_we),
		.waddr   (item.index),
		.wdata   (item.coefficient),
		.re      (adv),
		.raddr_a (src_idx),
		.raddr_b (item.index),
		.rdata_a (rot_raw),
		.rdata_b (cur_raw)
	);

	// tag that lines up with the registered memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1.valid      <= accept && (item.action == nmm_pkg::ACT_READ);
			tag_s1.index      <= item.index;
			tag_s1.negate     <= (item.index < rot_amt) != upper;
			tag_s1.force_zero <= idx_out_of_range || (modulus_q < W'(2));
		end
	end

	nmm_reduce u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.modulus (modulus_q),
		.tag_in  (tag_s1),
		.rot_in  (rot_raw),
		.cur_in  (cur_raw),
		.tag_out (red_tag),
		.rot_out (red_rot),
		.cur_out (red_cur)
	);

	nmm_combine u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.modulus   (modulus_q),
		.tag_in    (red_tag),
		.rot_in    (red_rot),
		.cur_in    (red_cur),
		.tag_out   (fin_tag),
		.value_out (fin_value)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= fin_tag.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_index_q <= fin_tag.index;
			result_value_q <= fin_value;
		end
	end

	assign result.valid        = result_valid_q;
	assign result.result_index = result_index_q;
	assign result.result_value = result_value_q;

	// results are reduced below the modulus when the modulus is at least two
	a_value_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (modulus_q >= W'(2)) |-> result.result_value < modulus_q)
		else $error("result word not below modulus");

	// degenerate modulus gives zero
	a_small_modulus_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (modulus_q < W'(2)) |-> result.result_value == '0)
		else $error("nonzero result under modulus below two");

	// a held result freezes the whole pipeline, input included
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !item.ready && !load_we)
		else $error("input taken while result is stalled");

endmodule

`default_nettype wire

FILE: tb/tb_negacyclic_monomial_mul_minus_one.sv
// Testbench for negacyclic_monomial_mul_minus_one: random and directed load/read words
// are checked against a built-in predictor of P(X)*(X^a - 1) mod (X^N + 1, q).
// Depends on nmm_pkg, nmm_item_if, nmm_result_if and the block's RTL.
`default_nettype none

module tb_negacyclic_monomial_mul_minus_one;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LATENCY     = 64;
	localparam int unsigned NUM_PHASES  = 7;
	localparam int unsigned PHASE_WORDS = 72;
	localparam int unsigned HOLD_PHASE  = 6;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned N           = nmm_pkg::POLY_DEGREE;
	localparam int unsigned CW          = nmm_pkg::COEF_W;
	localparam int unsigned IW          = nmm_pkg::IDX_W;
	localparam int unsigned SW          = nmm_pkg::SHIFT_W;
	localparam logic [CW-1:0] COEF_MAX  = '1;

	typedef struct {
		nmm_pkg::action_t action;
		logic [IW-1:0]    index;
		logic [CW-1:0]    coefficient;
		logic [SW-1:0]    shift_amount;
	} item_word_t;

	typedef struct {
		logic [IW-1:0] index;
		logic [CW-1:0] value;
	} coeff_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic modulus_we;
	logic [CW-1:0] modulus_wdata;

	nmm_item_if   item_ch();
	nmm_result_if result_ch();

	negacyclic_monomial_mul_minus_one DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.modulus_we    (modulus_we),
		.modulus_wdata (modulus_wdata),
		.item          (item_ch),
		.result        (result_ch)
	);

	// predictor state: stored polynomial and the current modulus
	logic [CW-1:0] coeff_store [N];
	logic [CW-1:0] modulus_model;

	// stimulus bookkeeping
	item_word_t        pending_words[$];
	coeff_word_t       expected_coeffs[$];
	bit                is_loaded [N];
	int unsigned       loaded_idx[$];

	int unsigned error_count = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	bit          hold_active = 1'b0;
	int unsigned held_cycles = 0;
	bit          item_taken  = 1'b0;
	int unsigned cycle_count = 0;

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// one output coefficient: s * P[(j - r) mod N] - P[j] mod q
	function automatic logic [CW-1:0] product_coeff(input logic [IW-1:0] j,
			input logic [SW-1:0] a);
		logic [63:0]   q;
		logic [63:0]   rot;
		logic [63:0]   cur;
		logic          upper;
		logic [IW-1:0] r;
		logic [IW-1:0] src;
		q = 64'(modulus_model);
		if (q < 64'd2)
			return '0;
		// the exponent field spans exactly [0, 2N) and the index wraps mod N
		upper = a[IW];
		r     = a[IW-1:0];
		src   = j - r;
		rot   = 64'(coeff_store[src]) % q;
		cur   = 64'(coeff_store[j]) % q;
		if (((j < r) != upper) && rot != 64'd0)
			rot = q - rot;
		return CW'(rot >= cur ? rot - cur : rot + (q - cur));
	endfunction

	function automatic logic [CW-1:0] pick_coeff();
		logic [CW-1:0] v;
		v = CW'({$urandom, $urandom});
		case ($urandom_range(7))
			0: v = '0;
			1: v = COEF_MAX;
			2: v = modulus_model - 1'b1;
			3: v = modulus_model;
			4, 5: if (modulus_model >= 2) v = CW'(64'(v) % 64'(modulus_model));
			default: ;
		endcase
		return v;
	endfunction

	task automatic push_load(input int unsigned idx, input logic [CW-1:0] coef);
		item_word_t w;
		w.action       = nmm_pkg::ACT_LOAD;
		w.index        = IW'(idx);
		w.coefficient  = coef;
		w.shift_amount = SW'($urandom);
		pending_words.push_back(w);
		if (!is_loaded[idx]) begin
			is_loaded[idx] = 1'b1;
			loaded_idx.push_back(idx);
		end
	endtask

	task automatic push_read(input int unsigned j, input int unsigned a);
		item_word_t w;
		w.action       = nmm_pkg::ACT_READ;
		w.index        = IW'(j);
		w.coefficient  = CW'({$urandom, $urandom});
		w.shift_amount = SW'(a);
		pending_words.push_back(w);
	endtask

	// read only pairs whose direct and rotated entries were both loaded
	task automatic push_random_read();
		int unsigned j;
		int unsigned src;
		int unsigned r;
		j   = loaded_idx[$urandom_range(loaded_idx.size() - 1)];
		src = loaded_idx[$urandom_range(loaded_idx.size() - 1)];
		r   = (j + N - src) % N;
		push_read(j, r + N * $urandom_range(1));
	endtask

	// wait until every word is taken and every result is back, then let loads settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || item_ch.valid || expected_coeffs.size() != 0);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	// input driver: offers the next pending word once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || item_taken) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				item_word_t w;
				w = pending_words.pop_front();
				item_ch.action       <= w.action;
				item_ch.index        <= w.index;
				item_ch.coefficient  <= w.coefficient;
				item_ch.shift_amount <= w.shift_amount;
				item_ch.valid        <= 1'b1;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// receiver ready, with one long hold-off to back the pipeline up
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_active && held_cycles < HOLD_CYCLES) begin
			held_cycles <= held_cycles + 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// monitor: check result words, predict accepted input words
	always @(posedge clk) begin
		coeff_word_t e;
		if (result_ch.valid && result_ch.ready) begin
			if (expected_coeffs.size() == 0) begin
				report_mismatch($sformatf("unexpected result word index %0d value %0d",
					result_ch.result_index, result_ch.result_value));
			end else begin
				e = expected_coeffs.pop_front();
				if (result_ch.result_index !== e.index)
					report_mismatch($sformatf("result_index %0d, expected %0d",
						result_ch.result_index, e.index));
				if (result_ch.result_value !== e.value)
					report_mismatch($sformatf("result_value %0d, expected %0d (index %0d)",
						result_ch.result_value, e.value, e.index));
			end
		end
		item_taken = arst_n && item_ch.valid && item_ch.ready;
		if (item_taken) begin
			if (nmm_pkg::action_t'(item_ch.action) == nmm_pkg::ACT_READ) begin
				e.index = item_ch.index;
				e.value = product_coeff(item_ch.index, item_ch.shift_amount);
				expected_coeffs.push_back(e);
			end else begin
				coeff_store[item_ch.index] = item_ch.coefficient;
			end
		end
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// stimulus sequencing
	initial begin
		logic [CW-1:0] phase_modulus [NUM_PHASES];
		phase_modulus[0] = nmm_pkg::MOD_RESET;
		phase_modulus[1] = CW'(2);
		phase_modulus[2] = COEF_MAX;
		phase_modulus[3] = '0;
		phase_modulus[4] = {1'b1, (CW-1)'({$urandom, $urandom})};
		phase_modulus[5] = CW'(1);
		phase_modulus[6] = CW'(65537);

		arst_n               = 1'b0;
		modulus_we           = 1'b0;
		modulus_wdata        = '0;
		item_ch.valid        = 1'b0;
		item_ch.action       = nmm_pkg::ACT_LOAD;
		item_ch.index        = '0;
		item_ch.coefficient  = '0;
		item_ch.shift_amount = '0;
		result_ch.ready      = 1'b0;
		modulus_model        = nmm_pkg::MOD_RESET;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				wait_idle();
				modulus_we    <= 1'b1;
				modulus_wdata <= phase_modulus[p];
				modulus_model  = phase_modulus[p];
				@(negedge clk);
				modulus_we <= 1'b0;
			end
			// receiver-heavy idling, then sender-heavy, then none
			if (p < 3) begin
				tx_idle_pct = 37;
				rx_idle_pct = 83;
			end else if (p < 5) begin
				tx_idle_pct = 83;
				rx_idle_pct = 37;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			if (p == 0) begin
				// extremes: unreduced max, q - 1, q itself, zero
				push_load(0, COEF_MAX);
				push_load(1, CW'(12288));
				push_load(511, CW'(5));
				push_load(512, CW'(12289));
				push_load(1022, CW'(7));
				push_load(1023, '0);
				push_read(0, 0);           // no shift gives zero
				push_read(0, 1);           // wrapped, negation of zero
				push_read(1023, 1);
				push_read(512, 1);
				push_read(0, 1024);        // upper half, no rotation
				push_read(1023, 2047);     // largest exponent
				push_read(1, 1025);
				push_read(1, 1537);        // upper half and wrapped
				push_read(1023, 1025);
				push_read(1, 513);         // rotated entry stored equal to q
				push_read(512, 0);
			end

			if (p == HOLD_PHASE)
				hold_active = 1'b1;

			for (int i = 0; i < PHASE_WORDS; i++) begin
				if ($urandom_range(99) < 30)
					push_load($urandom_range(N - 1), pick_coeff());
				else
					push_random_read();
			end
		end

		wait_idle();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
sv/nmm_pkg.sv
sv/nmm_item_if.sv
sv/nmm_result_if.sv
sv/nmm_ram.sv
sv/nmm_reduce.sv
sv/nmm_combine.sv
sv/negacyclic_monomial_mul_minus_one.sv
tb/tb_negacyclic_monomial_mul_minus_one.sv
